[sv/lss_pkg.sv]
// Package for the LIFO stack with search and remove.
// Holds sizes, request and status codes, the cell control types and the sequencer states.
// No dependencies; every other file of the block uses it.
package lss_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int INDEX_W   = 6;
  localparam int FILL_W    = 7;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SHIFT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic                rm_en;
    logic [IDX_BITS-1:0] rm_pos;
  } cell_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

endpackage

[sv/lss_cell.sv]
// One storage cell of the stack chain.
// Loads from the neighbor above, shifts in from the neighbor below, or holds.
// Depends on lss_pkg.
module lss_cell (
  input  logic              clk,
  input  lss_pkg::cell_op_t op,
  input  lss_pkg::word_t    up_word,
  input  lss_pkg::word_t    dn_word,
  output lss_pkg::word_t    word
);

  lss_pkg::word_t word_r;
  lss_pkg::word_t word_nxt;

  always_comb begin
    case (op)
      lss_pkg::OP_LOAD:  word_nxt = up_word;
      lss_pkg::OP_SHIFT: word_nxt = dn_word;
      default:           word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

[sv/lss_ctrl.sv]
// Sequencer of the stack: request decode, fill count, scan and result register.
// Drives the cell chain through a cell_ctl_t and watches the top cell.
// Depends on lss_pkg.
module lss_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic signed [31:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [5:0]               out_found_index,
  output logic signed [31:0]       out_top_value,
  output logic                     out_top_valid,
  output logic [6:0]               out_fill_count,
  input  lss_pkg::word_t           top_word,
  output lss_pkg::word_t           key,
  output lss_pkg::cell_ctl_t       ctl
);

  lss_pkg::state_t                 state_r, state_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  lss_pkg::word_t                  key_r, key_nxt;
  logic [lss_pkg::CNT_BITS-1:0]    count_r, count_nxt;
  logic [lss_pkg::IDX_BITS-1:0]    step_r, step_nxt;
  logic [lss_pkg::IDX_BITS-1:0]    hit_r, hit_nxt;
  logic                            found_r, found_nxt;
  logic [1:0]                      st_r, st_nxt;
  logic [lss_pkg::IDX_BITS-1:0]    idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      o_status_r, o_status_nxt;
  logic [5:0]                      o_index_r, o_index_nxt;
  logic signed [31:0]              o_top_r, o_top_nxt;
  logic                            o_topv_r, o_topv_nxt;
  logic [6:0]                      o_fill_r, o_fill_nxt;
  logic                            hit_now;
  logic [lss_pkg::IDX_BITS-1:0]    hit_pos;
  logic                            found_now;
  logic                            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign hit_now   = (top_word == key_r) &&
                     (lss_pkg::CNT_BITS'(step_r) < count_r);
  assign hit_pos   = hit_now ? step_r : hit_r;
  assign found_now = hit_now || found_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_status_nxt  = o_status_r;
    o_index_nxt   = o_index_r;
    o_top_nxt     = o_top_r;
    o_topv_nxt    = o_topv_r;
    o_fill_nxt    = o_fill_r;
    ctl.op        = lss_pkg::OP_HOLD;
    ctl.rm_en     = 1'b0;
    ctl.rm_pos    = hit_r;
    case (state_r)
      lss_pkg::S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = in_value[lss_pkg::WORD_BITS-1:0];
          state_nxt = lss_pkg::S_EXEC;
        end
      end
      lss_pkg::S_EXEC: begin
        st_nxt    = lss_pkg::ST_OK;
        idx_nxt   = '0;
        step_nxt  = '0;
        hit_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = lss_pkg::S_FINISH;
        case (kind_r)
          lss_pkg::KIND_PUSH: begin
            if (count_r == lss_pkg::CNT_BITS'(lss_pkg::DEPTH)) begin
              st_nxt = lss_pkg::ST_FULL;
            end else begin
              ctl.op    = lss_pkg::OP_LOAD;
              count_nxt = count_r + 1'b1;
            end
          end
          lss_pkg::KIND_POP: begin
            if (count_r == '0) begin
              st_nxt = lss_pkg::ST_EMPTY;
            end else begin
              ctl.op    = lss_pkg::OP_SHIFT;
              count_nxt = count_r - 1'b1;
            end
          end
          default: begin
            if (count_r == '0) begin
              st_nxt = lss_pkg::ST_NOTFOUND;
            end else begin
              state_nxt = lss_pkg::S_SCAN;
            end
          end
        endcase
      end
      lss_pkg::S_SCAN: begin
        ctl.op    = lss_pkg::OP_SHIFT;
        step_nxt  = step_r + 1'b1;
        hit_nxt   = hit_pos;
        found_nxt = found_now;
        if (step_r == lss_pkg::IDX_BITS'(lss_pkg::DEPTH - 1)) begin
          idx_nxt = lss_pkg::IDX_BITS'(count_r - 1'b1 - lss_pkg::CNT_BITS'(hit_pos));
          if (!found_now) begin
            st_nxt    = lss_pkg::ST_NOTFOUND;
            idx_nxt   = '0;
            state_nxt = lss_pkg::S_FINISH;
          end else if (kind_r == lss_pkg::KIND_REMOVE) begin
            state_nxt = lss_pkg::S_SHIFT;
          end else begin
            state_nxt = lss_pkg::S_FINISH;
          end
        end
      end
      lss_pkg::S_SHIFT: begin
        ctl.rm_en = 1'b1;
        count_nxt = count_r - 1'b1;
        state_nxt = lss_pkg::S_FINISH;
      end
      lss_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = st_r;
          o_index_nxt   = 6'(idx_r);
          o_top_nxt     = (count_r == '0) ? 32'sd0 : 32'(signed'(top_word));
          o_topv_nxt    = (count_r != '0);
          o_fill_nxt    = 7'(count_r);
          state_nxt     = lss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lss_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    step_r     <= step_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    st_r       <= st_nxt;
    idx_r      <= idx_nxt;
    o_status_r <= o_status_nxt;
    o_index_r  <= o_index_nxt;
    o_top_r    <= o_top_nxt;
    o_topv_r   <= o_topv_nxt;
    o_fill_r   <= o_fill_nxt;
  end

  assign in_stall        = (state_r != lss_pkg::S_IDLE);
  assign key             = key_r;
  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_found_index = o_index_r;
  assign out_top_value   = o_top_r;
  assign out_top_valid   = o_topv_r;
  assign out_fill_count  = o_fill_r;

endmodule

[sv/lifo_stack_with_search_remove.sv]
// Top level of the LIFO stack with search and remove: a chain of word cells
// with the top entry in cell 0, plus the sequencer. Depends on lss_pkg,
// lss_cell and lss_ctrl.
//
//   channel   ports                                         direction
//   input     in_valid, in_stall, in_kind, in_value         request in
//   result    out_valid, out_stall, out_status,             result out
//             out_found_index, out_top_value,
//             out_top_valid, out_fill_count
//
// Push and pop pass through the execute and finish states to the result register;
// search adds a scan state for one full rotation of the cell chain past the
// comparator on cell 0, remove a shift state after it. Requests are accepted in idle.
// Reset clears the fill count and the control state; cell contents are not reset.
// A stalled result stays in the output register while the next item is accepted.
module lifo_stack_with_search_remove (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic signed [31:0] out_top_value,
  output logic               out_top_valid,
  output logic [6:0]         out_fill_count
);

  lss_pkg::word_t     words [lss_pkg::DEPTH];
  lss_pkg::word_t     key;
  lss_pkg::cell_ctl_t ctl;

  lss_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_top_value   (out_top_value),
    .out_top_valid   (out_top_valid),
    .out_fill_count  (out_fill_count),
    .top_word        (words[0]),
    .key             (key),
    .ctl             (ctl)
  );

  for (genvar i = 0; i < lss_pkg::DEPTH; i++) begin : g_cell
    lss_pkg::cell_op_t op;
    lss_pkg::word_t    up_word;
    lss_pkg::word_t    dn_word;

    assign op = (ctl.rm_en && (lss_pkg::IDX_BITS'(i) >= ctl.rm_pos)) ?
                lss_pkg::OP_SHIFT : ctl.op;

    if (i == 0) begin : g_first
      assign up_word = key;
    end else begin : g_mid
      assign up_word = words[i-1];
    end

    if (i == lss_pkg::DEPTH - 1) begin : g_last
      assign dn_word = words[0];
    end else begin : g_inner
      assign dn_word = words[i+1];
    end

    lss_cell u_cell (
      .clk     (clk),
      .op      (op),
      .up_word (up_word),
      .dn_word (dn_word),
      .word    (words[i])
    );
  end

endmodule

[tb/tb_lifo_stack_with_search_remove.sv]
// Self-checking testbench for lifo_stack_with_search_remove: directed requests,
// then random push, pop, search and remove traffic checked against a predictor.
// Depends on lss_pkg and the RTL of the block only.
module tb_lifo_stack_with_search_remove;

  localparam int N_RANDOM        = 850;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic [1:0]                  status;
    logic [lss_pkg::INDEX_W-1:0] found_index;
    logic signed [31:0]          top_value;
    logic                        top_valid;
    logic [lss_pkg::FILL_W-1:0]  fill_count;
  } stack_result_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               typed;
    stack_result_t      want;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = lss_pkg::KIND_PUSH;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [5:0]         out_found_index;
  logic signed [31:0] out_top_value;
  logic               out_top_valid;
  logic [6:0]         out_fill_count;

  lss_pkg::word_t stack_words [lss_pkg::DEPTH];
  int unsigned    stack_fill = 0;
  stack_result_t  pending_results [$];
  directed_row_t  directed_rows [$];
  int             error_count = 0;
  int             results_seen = 0;
  logic           idle_on = 1'b1;
  logic           pressure_done = 1'b0;

  lifo_stack_with_search_remove u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_top_value   (out_top_value),
    .out_top_valid   (out_top_valid),
    .out_fill_count  (out_fill_count)
  );

  always #1 clk = ~clk;

  function automatic stack_result_t predict_stack_request(input logic [1:0] kind,
                                                         input logic signed [31:0] value);
    stack_result_t  r;
    lss_pkg::word_t key;
    int unsigned    pos;
    key = lss_pkg::word_t'(value);
    r.status = lss_pkg::ST_OK;
    r.found_index = '0;
    pos = stack_fill;
    if (kind == lss_pkg::KIND_SEARCH || kind == lss_pkg::KIND_REMOVE) begin
      for (int unsigned i = 0; i < stack_fill; i++) begin
        if (pos == stack_fill && stack_words[i] == key) begin
          pos = i;
        end
      end
    end
    case (kind)
      lss_pkg::KIND_PUSH: begin
        if (stack_fill >= lss_pkg::DEPTH) begin
          r.status = lss_pkg::ST_FULL;
        end else begin
          stack_words[stack_fill] = key;
          stack_fill++;
        end
      end
      lss_pkg::KIND_POP: begin
        if (stack_fill == 0) begin
          r.status = lss_pkg::ST_EMPTY;
        end else begin
          stack_fill--;
        end
      end
      lss_pkg::KIND_SEARCH: begin
        if (pos >= stack_fill) begin
          r.status = lss_pkg::ST_NOTFOUND;
        end else begin
          r.found_index = lss_pkg::INDEX_W'(pos);
        end
      end
      default: begin
        if (pos >= stack_fill) begin
          r.status = lss_pkg::ST_NOTFOUND;
        end else begin
          r.found_index = lss_pkg::INDEX_W'(pos);
          for (int unsigned j = pos; j + 1 < stack_fill; j++) begin
            stack_words[j] = stack_words[j + 1];
          end
          stack_fill--;
        end
      end
    endcase
    if (stack_fill > 0) begin
      r.top_value = $signed(stack_words[stack_fill - 1]);
      r.top_valid = 1'b1;
    end else begin
      r.top_value = '0;
      r.top_valid = 1'b0;
    end
    r.fill_count = lss_pkg::FILL_W'(stack_fill);
    return r;
  endfunction

  function automatic logic signed [31:0] pool_value(input int unsigned sel);
    case (sel % 6)
      0: return 32'sh0000_0000;
      1: return 32'shFFFF_FFFF;
      2: return 32'sh8000_0000;
      3: return 32'sh7FFF_FFFF;
      4: return 32'sh0000_0001;
      default: return 32'sh5A5A_A5A5;
    endcase
  endfunction

  task automatic table_row(input logic [1:0] kind, input logic signed [31:0] value,
                           input logic [1:0] status,
                           input logic [lss_pkg::INDEX_W-1:0] idx,
                           input logic signed [31:0] top, input logic top_valid,
                           input logic [lss_pkg::FILL_W-1:0] fill);
    directed_row_t row;
    row.kind = kind;
    row.value = value;
    row.typed = 1'b1;
    row.want = '{status, idx, top, top_valid, fill};
    directed_rows.push_back(row);
  endtask

  task automatic offer_request(input logic [1:0] kind, input logic signed [31:0] value,
                               input logic typed, input stack_result_t want);
    stack_result_t predicted;
    int unsigned   gap;
    int unsigned   dice;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_stack_request(kind, value);
    pending_results.push_back(typed ? want : predicted);
    dice = $urandom_range(0, 19);
    if (!idle_on || dice < 12) begin
      gap = 0;
    end else if (dice < 18) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    logic [1:0]         kind;
    logic signed [31:0] value;
    int unsigned        dice;
    logic               filling;
    stack_result_t      unused;

    unused = '0;
    filling = 1'b1;
    table_row(lss_pkg::KIND_POP,    32'sh0000_0000, lss_pkg::ST_EMPTY,    6'd0,
              32'sh0000_0000, 1'b0, 7'd0);
    table_row(lss_pkg::KIND_SEARCH, 32'sh0000_0000, lss_pkg::ST_NOTFOUND, 6'd0,
              32'sh0000_0000, 1'b0, 7'd0);
    table_row(lss_pkg::KIND_REMOVE, 32'shFFFF_FFFF, lss_pkg::ST_NOTFOUND, 6'd0,
              32'sh0000_0000, 1'b0, 7'd0);
    table_row(lss_pkg::KIND_PUSH,   32'sh8000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh8000_0000, 1'b1, 7'd1);
    table_row(lss_pkg::KIND_PUSH,   32'sh7FFF_FFFF, lss_pkg::ST_OK,       6'd0,
              32'sh7FFF_FFFF, 1'b1, 7'd2);
    table_row(lss_pkg::KIND_PUSH,   32'sh0000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh0000_0000, 1'b1, 7'd3);
    table_row(lss_pkg::KIND_PUSH,   32'shFFFF_FFFF, lss_pkg::ST_OK,       6'd0,
              32'shFFFF_FFFF, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_SEARCH, 32'sh8000_0000, lss_pkg::ST_OK,       6'd0,
              32'shFFFF_FFFF, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_SEARCH, 32'shFFFF_FFFF, lss_pkg::ST_OK,       6'd3,
              32'shFFFF_FFFF, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_SEARCH, 32'sh0000_0005, lss_pkg::ST_NOTFOUND, 6'd0,
              32'shFFFF_FFFF, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_PUSH,   32'sh8000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh8000_0000, 1'b1, 7'd5);
    table_row(lss_pkg::KIND_SEARCH, 32'sh8000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh8000_0000, 1'b1, 7'd5);
    table_row(lss_pkg::KIND_REMOVE, 32'sh8000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh8000_0000, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_SEARCH, 32'sh8000_0000, lss_pkg::ST_OK,       6'd3,
              32'sh8000_0000, 1'b1, 7'd4);
    table_row(lss_pkg::KIND_REMOVE, 32'sh0000_0000, lss_pkg::ST_OK,       6'd1,
              32'sh8000_0000, 1'b1, 7'd3);
    table_row(lss_pkg::KIND_REMOVE, 32'sh8000_0000, lss_pkg::ST_OK,       6'd2,
              32'shFFFF_FFFF, 1'b1, 7'd2);
    table_row(lss_pkg::KIND_POP,    32'sh0000_0000, lss_pkg::ST_OK,       6'd0,
              32'sh7FFF_FFFF, 1'b1, 7'd1);
    table_row(lss_pkg::KIND_REMOVE, 32'sh0000_0007, lss_pkg::ST_NOTFOUND, 6'd0,
              32'sh7FFF_FFFF, 1'b1, 7'd1);
    table_row(lss_pkg::KIND_SEARCH, 32'sh7FFF_FFFF, lss_pkg::ST_OK,       6'd0,
              32'sh7FFF_FFFF, 1'b1, 7'd1);
    table_row(lss_pkg::KIND_REMOVE, 32'sh7FFF_FFFF, lss_pkg::ST_OK,       6'd0,
              32'sh0000_0000, 1'b0, 7'd0);
    table_row(lss_pkg::KIND_POP,    32'shFFFF_FFFF, lss_pkg::ST_EMPTY,    6'd0,
              32'sh0000_0000, 1'b0, 7'd0);
    table_row(lss_pkg::KIND_PUSH,   32'sh5555_AAAA, lss_pkg::ST_OK,       6'd0,
              32'sh5555_AAAA, 1'b1, 7'd1);
    table_row(lss_pkg::KIND_POP,    32'shAAAA_5555, lss_pkg::ST_OK,       6'd0,
              32'sh0000_0000, 1'b0, 7'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].kind, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].want);
    end

    // The random part alternates between filling toward full and draining
    // toward empty, so that overflow and underflow are reached repeatedly.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        idle_on <= ($urandom_range(0, 3) != 0);
      end
      if (filling && stack_fill == lss_pkg::DEPTH && $urandom_range(0, 3) == 0) begin
        filling = 1'b0;
      end else if (!filling && stack_fill == 0 && $urandom_range(0, 2) == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(0, 149) == 0) begin
        filling = !filling;
      end
      dice = $urandom_range(0, 99);
      if (filling) begin
        kind = (dice < 75) ? lss_pkg::KIND_PUSH : (dice < 85) ? lss_pkg::KIND_POP :
               (dice < 93) ? lss_pkg::KIND_SEARCH : lss_pkg::KIND_REMOVE;
      end else begin
        kind = (dice < 20) ? lss_pkg::KIND_PUSH : (dice < 55) ? lss_pkg::KIND_POP :
               (dice < 75) ? lss_pkg::KIND_SEARCH : lss_pkg::KIND_REMOVE;
      end
      dice = $urandom_range(0, 99);
      if ((kind == lss_pkg::KIND_SEARCH || kind == lss_pkg::KIND_REMOVE) &&
          stack_fill > 0 && dice < 70) begin
        value = $signed(stack_words[$urandom_range(0, stack_fill - 1)]);
      end else if (kind != lss_pkg::KIND_POP && dice < 85) begin
        value = pool_value($urandom);
      end else begin
        value = $urandom;
      end
      offer_request(kind, value, 1'b0, unused);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (lss_pkg::DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side pacing. One long hold-off lets the block back up until it
  // stalls its input while requests keep coming.
  initial begin : result_pacing
    int unsigned hold_len;
    int unsigned run_len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= 150) begin
        pressure_done <= 1'b1;
        hold_len = PRESSURE_CYCLES;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        hold_len = 0;
      end
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      run_len = $urandom_range(1, 8);
      repeat (run_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result item arrived with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, out_found_index);
          error_count++;
        end
        if (out_top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, out_top_value);
          error_count++;
        end
        if (out_top_valid !== want.top_valid) begin
          $error("top_valid: expected %0d, got %0d", want.top_valid, out_top_valid);
          error_count++;
        end
        if (out_fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, out_fill_count);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
